@@ rtl/wmw_pkg.sv @@
// ============================================================================
// wmw_pkg
// Shared sizes, field widths and codes of the weighted Markov walk block.
// ============================================================================
package wmw_pkg;

    // table geometry
    localparam int RULE_COUNT  = 16;
    localparam int SLOT_COUNT  = 8;
    localparam int WEIGHT_BITS = 16;

    // fixed field widths
    localparam int KIND_W  = 2;
    localparam int RULE_W  = 4;
    localparam int SLOT_W  = 3;
    localparam int WVAL_W  = 16;
    localparam int RAND_W  = 31;
    localparam int COUNT_W = 8;

    localparam int RULE_IDX_BITS = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;
    localparam int SLOT_IDX_BITS = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int TABLE_DEPTH   = RULE_COUNT * SLOT_COUNT;
    localparam int ADDR_BITS     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    // a rule total holds up to SLOT_COUNT full-scale weights
    localparam int TOTAL_BITS    = WEIGHT_BITS + $clog2(SLOT_COUNT);
    localparam int LINK_W        = WEIGHT_BITS + RULE_W;
    localparam int MOD_CNT_BITS  = $clog2(RAND_W + 1);

    // stream payload widths
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 24;

    // config port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_NAME_LENGTH   = 2'd0;
    localparam logic [COUNT_W-1:0] NAME_LENGTH_RESET = 8'd8;

    typedef enum logic [KIND_W-1:0] {
        KIND_SYMBOL = 2'd0,
        KIND_LINK   = 2'd1,
        KIND_START  = 2'd2,
        KIND_STEP   = 2'd3
    } kind_t;

endpackage

@@ rtl/wmw_ram.sv @@
// ============================================================================
// wmw_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module wmw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/wmw_mod.sv @@
// ============================================================================
// wmw_mod
// Radix-2 restoring modulo unit: one dividend bit per cycle.
// ============================================================================
module wmw_mod (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [wmw_pkg::RAND_W-1:0]       dividend,
    input  logic [wmw_pkg::TOTAL_BITS-1:0]   divisor,
    output logic                             done,
    output logic [wmw_pkg::TOTAL_BITS-1:0]   remainder
);

    logic [wmw_pkg::TOTAL_BITS-1:0]   rem_reg;
    logic [wmw_pkg::TOTAL_BITS-1:0]   div_reg;
    logic [wmw_pkg::RAND_W-1:0]       dvd_reg;
    logic [wmw_pkg::MOD_CNT_BITS-1:0] cnt_reg;
    logic                             busy_reg;
    logic                             done_reg;

    logic [wmw_pkg::TOTAL_BITS:0]     shifted;
    logic [wmw_pkg::TOTAL_BITS:0]     diff;
    logic                             fits;

    // partial remainder stays below the divisor, so the shifted value fits one extra bit
    assign shifted = {rem_reg, dvd_reg[wmw_pkg::RAND_W-1]};
    assign diff    = shifted - {1'b0, div_reg};
    assign fits    = (shifted >= {1'b0, div_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == wmw_pkg::MOD_CNT_BITS'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= wmw_pkg::MOD_CNT_BITS'(wmw_pkg::RAND_W);
            end
            else if (busy_reg)
            begin
                cnt_reg  <= cnt_reg - wmw_pkg::MOD_CNT_BITS'(1);
                busy_reg <= (cnt_reg != wmw_pkg::MOD_CNT_BITS'(1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            div_reg <= divisor;
            dvd_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[wmw_pkg::TOTAL_BITS-1:0]
                            : shifted[wmw_pkg::TOTAL_BITS-1:0];
            dvd_reg <= {dvd_reg[wmw_pkg::RAND_W-2:0], 1'b0};
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

@@ rtl/weighted_markov_walk.sv @@
// ============================================================================
// weighted_markov_walk
// Weighted random walk over a table of rules with symbol and connection slots.
// ============================================================================
//
//  channel  dir  handshake        payload
//  -------  ---  ---------------  ------------------------------------------
//  s_*      in   tvalid/tready    tuser: kind; tdata: table write or randoms
//  m_*      out  tvalid/tready    tuser: emitted; tdata: symbol, rule, count;
//                                 tlast: walk_done
//  apb      in   psel/penable     name_length at byte address 0
//
//  Table write: accept, read the old weight, then update total and table.
//  Start, or step on an ended walk: accept, then the result state.
//  Step: one or two modulo passes, each followed by a slot scan that reads
//  and then checks one slot at a time through the single read port of each
//  table; the radix-2 modulo unit takes one bit per cycle and serves both passes.
//  Reset clears the tables through per-entry valid bits and zeroes all totals.
//  s_tready is high only while the sequencer is idle; a result waiting on a
//  full output register holds the sequencer in its result state, and s_tready
//  stays low until the result moves out.
//
module weighted_markov_walk (
    input  logic                              clk,
    input  logic                              rst_n,
    // config
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wmw_pkg::PADDR_W-1:0]       paddr,
    input  logic [wmw_pkg::PDATA_W-1:0]       pwdata,
    output logic [wmw_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready,
    // input items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // rule_index[3:0], slot_index[6:4], weight_value[22:7], target_rule[26:23],
    // random_symbol[57:27], random_connection[88:58], zero pad
    input  logic [wmw_pkg::S_TDATA_W-1:0]     s_tdata,
    // kind[1:0]
    input  logic [wmw_pkg::KIND_W-1:0]        s_tuser,
    // results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // symbol_rule[3:0], symbol_slot[6:4], next_rule[10:7],
    // symbols_emitted[18:11], zero pad
    output logic [wmw_pkg::M_TDATA_W-1:0]     m_tdata,
    // emitted[0]
    output logic [0:0]                        m_tuser,
    output logic                              m_tlast
);

    typedef enum logic [10:0] {
        ST_IDLE    = 11'b000_0000_0001,
        ST_WR_RD   = 11'b000_0000_0010,
        ST_WR_UPD  = 11'b000_0000_0100,
        ST_SYM_GO  = 11'b000_0000_1000,
        ST_SYM_MOD = 11'b000_0001_0000,
        ST_SYM_RD  = 11'b000_0010_0000,
        ST_SYM_CK  = 11'b000_0100_0000,
        ST_LNK_GO  = 11'b000_1000_0000,
        ST_LNK_MOD = 11'b001_0000_0000,
        ST_LNK_RD  = 11'b010_0000_0000,
        ST_LNK_CK  = 11'b100_0000_0000
    } state_t;

    // result state shares the idle path through a flag to keep the codes one-hot
    state_t state_reg;
    state_t state_next;
    logic   result_reg;
    logic   result_next;

    logic [wmw_pkg::COUNT_W-1:0]      name_length_reg;

    // captured item
    wmw_pkg::kind_t                   kind_reg;
    logic [wmw_pkg::RULE_W-1:0]       ri_reg;
    logic [wmw_pkg::SLOT_W-1:0]       si_reg;
    logic [wmw_pkg::WEIGHT_BITS-1:0]  wv_reg;
    logic [wmw_pkg::RULE_W-1:0]       tr_reg;
    logic [wmw_pkg::RAND_W-1:0]       rs_reg;
    logic [wmw_pkg::RAND_W-1:0]       rc_reg;

    // walk state
    logic [wmw_pkg::RULE_W-1:0]       cur_reg;
    logic [wmw_pkg::COUNT_W-1:0]      count_reg;
    logic                             finished_reg;
    logic                             em_reg;
    logic [wmw_pkg::RULE_W-1:0]       er_reg;
    logic [wmw_pkg::SLOT_W-1:0]       es_reg;

    logic [wmw_pkg::TOTAL_BITS-1:0]   sym_total_reg  [wmw_pkg::RULE_COUNT];
    logic [wmw_pkg::TOTAL_BITS-1:0]   link_total_reg [wmw_pkg::RULE_COUNT];
    logic [wmw_pkg::TABLE_DEPTH-1:0]  sym_valid_reg;
    logic [wmw_pkg::TABLE_DEPTH-1:0]  link_valid_reg;
    logic                             rd_valid_reg;

    logic [wmw_pkg::SLOT_IDX_BITS-1:0] k_reg;
    logic [wmw_pkg::TOTAL_BITS-1:0]    acc_reg;

    logic                             m_valid_reg;
    logic [wmw_pkg::M_TDATA_W-1:0]    m_data_reg;
    logic                             m_user_reg;
    logic                             m_last_reg;

    // input fields
    wmw_pkg::kind_t                   kind_f;
    logic [wmw_pkg::RULE_W-1:0]       ri_f;
    logic [wmw_pkg::SLOT_W-1:0]       si_f;
    logic [wmw_pkg::WVAL_W-1:0]       wv_f;
    logic [wmw_pkg::RULE_W-1:0]       tr_f;
    logic                             idx_ok;
    logic                             tr_ok;
    logic                             s_accept;

    logic [wmw_pkg::RULE_IDX_BITS-1:0] cur_idx;
    logic [wmw_pkg::RULE_IDX_BITS-1:0] ri_idx;
    logic [wmw_pkg::TOTAL_BITS-1:0]    cur_sym_total;
    logic [wmw_pkg::TOTAL_BITS-1:0]    cur_link_total;
    logic                              len_reached;

    // table access
    logic [wmw_pkg::ADDR_BITS-1:0]    wr_addr;
    logic [wmw_pkg::ADDR_BITS-1:0]    scan_addr;
    logic [wmw_pkg::ADDR_BITS-1:0]    rd_addr;
    logic                             rd_sym;
    logic                             sym_we;
    logic                             link_we;
    logic [wmw_pkg::WEIGHT_BITS-1:0]  sym_rdata;
    logic [wmw_pkg::LINK_W-1:0]       link_rdata;
    logic [wmw_pkg::WEIGHT_BITS-1:0]  sym_w;
    logic [wmw_pkg::WEIGHT_BITS-1:0]  link_w;
    logic [wmw_pkg::RULE_W-1:0]       link_t;

    // write update
    logic [wmw_pkg::WEIGHT_BITS-1:0]  old_w;
    logic [wmw_pkg::TOTAL_BITS-1:0]   old_total;
    logic [wmw_pkg::TOTAL_BITS-1:0]   new_total;

    // scan
    logic [wmw_pkg::WEIGHT_BITS-1:0]  scan_w;
    logic [wmw_pkg::TOTAL_BITS-1:0]   acc_sum;
    logic                             hit;

    // modulo unit
    logic                             mod_start;
    logic [wmw_pkg::RAND_W-1:0]       mod_dividend;
    logic [wmw_pkg::TOTAL_BITS-1:0]   mod_divisor;
    logic                             mod_done;
    logic [wmw_pkg::TOTAL_BITS-1:0]   mod_rem;

    logic                             cfg_write;
    logic                             out_free;

    // ------------------------------------------------------------------------
    // config port
    // ------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[wmw_pkg::PADDR_W-1:2] == wmw_pkg::REG_NAME_LENGTH);
    assign prdata    = (paddr[wmw_pkg::PADDR_W-1:2] == wmw_pkg::REG_NAME_LENGTH)
                       ? {{(wmw_pkg::PDATA_W-wmw_pkg::COUNT_W){1'b0}}, name_length_reg}
                       : '0;

    // ------------------------------------------------------------------------
    // input decode
    // ------------------------------------------------------------------------
    assign kind_f = wmw_pkg::kind_t'(s_tuser);
    assign ri_f   = s_tdata[3:0];
    assign si_f   = s_tdata[6:4];
    assign wv_f   = s_tdata[22:7];
    assign tr_f   = s_tdata[26:23];

    assign idx_ok   = (int'(ri_f) < wmw_pkg::RULE_COUNT) && (int'(si_f) < wmw_pkg::SLOT_COUNT);
    assign tr_ok    = (int'(tr_f) < wmw_pkg::RULE_COUNT);
    assign s_tready = (state_reg == ST_IDLE) && !result_reg;
    assign s_accept = s_tvalid && s_tready;

    assign cur_idx        = wmw_pkg::RULE_IDX_BITS'(cur_reg);
    assign ri_idx         = wmw_pkg::RULE_IDX_BITS'(ri_reg);
    assign cur_sym_total  = sym_total_reg[cur_idx];
    assign cur_link_total = link_total_reg[cur_idx];
    assign len_reached    = (count_reg >= name_length_reg);

    // ------------------------------------------------------------------------
    // tables
    // ------------------------------------------------------------------------
    assign wr_addr   = wmw_pkg::ADDR_BITS'(int'(ri_reg) * wmw_pkg::SLOT_COUNT + int'(si_reg));
    assign scan_addr = wmw_pkg::ADDR_BITS'(int'(cur_reg) * wmw_pkg::SLOT_COUNT + int'(k_reg));
    assign rd_addr   = (state_reg == ST_WR_RD) ? wr_addr : scan_addr;
    assign rd_sym    = (state_reg == ST_WR_RD) ? (kind_reg == wmw_pkg::KIND_SYMBOL)
                                               : (state_reg == ST_SYM_RD);
    assign sym_we    = (state_reg == ST_WR_UPD) && (kind_reg == wmw_pkg::KIND_SYMBOL);
    assign link_we   = (state_reg == ST_WR_UPD) && (kind_reg == wmw_pkg::KIND_LINK);

    wmw_ram #(
        .WIDTH (wmw_pkg::WEIGHT_BITS),
        .DEPTH (wmw_pkg::TABLE_DEPTH)
    ) u_sym_ram (
        .clk   (clk),
        .we    (sym_we),
        .waddr (wr_addr),
        .wdata (wv_reg),
        .raddr (rd_addr),
        .rdata (sym_rdata)
    );

    wmw_ram #(
        .WIDTH (wmw_pkg::LINK_W),
        .DEPTH (wmw_pkg::TABLE_DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (wr_addr),
        .wdata ({tr_reg, wv_reg}),
        .raddr (rd_addr),
        .rdata (link_rdata)
    );

    // never-written entries read as zero
    assign sym_w  = rd_valid_reg ? sym_rdata : '0;
    assign link_w = rd_valid_reg ? link_rdata[wmw_pkg::WEIGHT_BITS-1:0] : '0;
    assign link_t = rd_valid_reg ? link_rdata[wmw_pkg::LINK_W-1:wmw_pkg::WEIGHT_BITS] : '0;

    assign old_w     = (kind_reg == wmw_pkg::KIND_SYMBOL) ? sym_w : link_w;
    assign old_total = (kind_reg == wmw_pkg::KIND_SYMBOL) ? sym_total_reg[ri_idx]
                                                          : link_total_reg[ri_idx];
    assign new_total = old_total - wmw_pkg::TOTAL_BITS'(old_w)
                                 + wmw_pkg::TOTAL_BITS'(wv_reg);

    // ------------------------------------------------------------------------
    // cumulative scan and shared modulo unit
    // ------------------------------------------------------------------------
    assign scan_w  = (state_reg == ST_SYM_CK) ? sym_w : link_w;
    assign acc_sum = acc_reg + wmw_pkg::TOTAL_BITS'(scan_w);
    assign hit     = (acc_sum > mod_rem)
                     || (k_reg == wmw_pkg::SLOT_IDX_BITS'(wmw_pkg::SLOT_COUNT - 1));

    assign mod_start    = (state_reg == ST_SYM_GO) || (state_reg == ST_LNK_GO);
    assign mod_dividend = (state_reg == ST_LNK_GO) ? rc_reg : rs_reg;
    assign mod_divisor  = (state_reg == ST_LNK_GO) ? cur_link_total : cur_sym_total;

    wmw_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (mod_dividend),
        .divisor   (mod_divisor),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign out_free = !m_valid_reg || m_tready;

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next  = state_reg;
        result_next = result_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (result_reg)
                begin
                    if (out_free)
                    begin
                        result_next = 1'b0;
                    end
                end
                else if (s_accept)
                begin
                    case (kind_f)
                        wmw_pkg::KIND_SYMBOL: state_next = idx_ok ? ST_WR_RD : ST_IDLE;
                        wmw_pkg::KIND_LINK:   state_next = (idx_ok && tr_ok) ? ST_WR_RD : ST_IDLE;
                        wmw_pkg::KIND_START:  result_next = 1'b1;
                        wmw_pkg::KIND_STEP:
                        begin
                            if (finished_reg || len_reached)
                            begin
                                result_next = 1'b1;
                            end
                            else if (cur_sym_total != '0)
                            begin
                                state_next = ST_SYM_GO;
                            end
                            else if (cur_link_total == '0)
                            begin
                                result_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_LNK_GO;
                            end
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WR_RD:   state_next = ST_WR_UPD;
            ST_WR_UPD:  state_next = ST_IDLE;
            ST_SYM_GO:  state_next = ST_SYM_MOD;
            ST_SYM_MOD: state_next = mod_done ? ST_SYM_RD : ST_SYM_MOD;
            ST_SYM_RD:  state_next = ST_SYM_CK;
            ST_SYM_CK:
            begin
                if (!hit)
                begin
                    state_next = ST_SYM_RD;
                end
                else if (cur_link_total == '0)
                begin
                    state_next  = ST_IDLE;
                    result_next = 1'b1;
                end
                else
                begin
                    state_next = ST_LNK_GO;
                end
            end
            ST_LNK_GO:  state_next = ST_LNK_MOD;
            ST_LNK_MOD: state_next = mod_done ? ST_LNK_RD : ST_LNK_MOD;
            ST_LNK_RD:  state_next = ST_LNK_CK;
            ST_LNK_CK:
            begin
                if (hit)
                begin
                    state_next  = ST_IDLE;
                    result_next = 1'b1;
                end
                else
                begin
                    state_next = ST_LNK_RD;
                end
            end
            default:
            begin
                state_next  = ST_IDLE;
                result_next = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            result_reg      <= 1'b0;
            name_length_reg <= wmw_pkg::NAME_LENGTH_RESET;
            cur_reg         <= '0;
            count_reg       <= '0;
            finished_reg    <= 1'b1;
            sym_valid_reg   <= '0;
            link_valid_reg  <= '0;
            m_valid_reg     <= 1'b0;
            for (int i = 0; i < wmw_pkg::RULE_COUNT; i++)
            begin
                sym_total_reg[i]  <= '0;
                link_total_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            result_reg <= result_next;

            if (cfg_write)
            begin
                name_length_reg <= pwdata[wmw_pkg::COUNT_W-1:0];
            end

            if (result_reg && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            if (s_accept && (kind_f == wmw_pkg::KIND_START))
            begin
                cur_reg      <= '0;
                count_reg    <= '0;
                finished_reg <= (name_length_reg == '0);
            end

            if (s_accept && (kind_f == wmw_pkg::KIND_STEP) && !finished_reg)
            begin
                // length reached, or nothing to emit and nowhere to go
                if (len_reached || ((cur_sym_total == '0) && (cur_link_total == '0)))
                begin
                    finished_reg <= 1'b1;
                end
            end

            if (state_reg == ST_WR_UPD)
            begin
                if (kind_reg == wmw_pkg::KIND_SYMBOL)
                begin
                    sym_total_reg[ri_idx]  <= new_total;
                    sym_valid_reg[wr_addr] <= 1'b1;
                end
                else
                begin
                    link_total_reg[ri_idx]  <= new_total;
                    link_valid_reg[wr_addr] <= 1'b1;
                end
            end

            if ((state_reg == ST_SYM_CK) && hit)
            begin
                count_reg <= count_reg + wmw_pkg::COUNT_W'(1);
                if (cur_link_total == '0)
                begin
                    finished_reg <= 1'b1;
                end
            end

            if ((state_reg == ST_LNK_CK) && hit)
            begin
                cur_reg <= (int'(link_t) < wmw_pkg::RULE_COUNT) ? link_t : '0;
                if (len_reached)
                begin
                    finished_reg <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        rd_valid_reg <= rd_sym ? sym_valid_reg[rd_addr] : link_valid_reg[rd_addr];

        if (s_accept)
        begin
            kind_reg <= kind_f;
            ri_reg   <= ri_f;
            si_reg   <= si_f;
            wv_reg   <= wmw_pkg::WEIGHT_BITS'(wv_f);
            tr_reg   <= tr_f;
            rs_reg   <= s_tdata[57:27];
            rc_reg   <= s_tdata[88:58];
            em_reg   <= 1'b0;
            er_reg   <= '0;
            es_reg   <= '0;
        end

        if (mod_start)
        begin
            k_reg   <= '0;
            acc_reg <= '0;
        end

        if ((state_reg == ST_SYM_CK) || (state_reg == ST_LNK_CK))
        begin
            if (hit)
            begin
                k_reg   <= '0;
                acc_reg <= '0;
            end
            else
            begin
                k_reg   <= k_reg + wmw_pkg::SLOT_IDX_BITS'(1);
                acc_reg <= acc_sum;
            end
        end

        if ((state_reg == ST_SYM_CK) && hit)
        begin
            em_reg <= 1'b1;
            er_reg <= cur_reg;
            es_reg <= wmw_pkg::SLOT_W'(k_reg);
        end

        if (result_reg && out_free)
        begin
            m_data_reg <= {{(wmw_pkg::M_TDATA_W - 19){1'b0}}, count_reg, cur_reg,
                           es_reg, er_reg};
            m_user_reg <= em_reg;
            m_last_reg <= finished_reg;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;
    assign m_tlast    = m_last_reg;

endmodule

@@ rtl/wmw_checker.sv @@
// ============================================================================
// wmw_checker
// Port-level checks of the weighted Markov walk block, bound to the top level.
// ============================================================================
module wmw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);

    // start and step items always drop s_tready in the cycle after they are taken
    a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser[1] |=> !s_tready)
        else $error("input taken right after a start or step item");

    // table writes produce no result
    a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tuser[1] |=> !$rose(m_tvalid))
        else $error("result raised by a table write");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // no symbol: symbol rule and slot read zero
    a_no_emit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[6:0] == 7'd0)
        else $error("symbol fields set without an emitted symbol");

    // an emitted symbol leaves a nonzero count
    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[18:11] != 8'd0)
        else $error("symbol emitted with zero count");

endmodule

bind weighted_markov_walk wmw_checker u_wmw_checker (.*);

@@ bench/weighted_markov_walk_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// weighted_markov_walk_tb
// Self-checking bench for the weighted Markov walk block. Table writes, walk
// starts and walk steps are streamed in, and every result is compared with a
// behavioral copy of the rule tables and the walk state. Directed cases cover
// weight and random-value extremes, rules without symbols or connections, and
// the walk length limits. Random walks follow, with bursty input, receiver
// stalls and one long receiver hold-off that backs up the input.
// ============================================================================
module weighted_markov_walk_tb;

    localparam int RANDOM_ITEMS = 410;
    localparam int HOLD_CYCLES  = 400;
    // settle time, longer than the longest step in the block
    localparam int SETTLE_CYCLES = 150;

    typedef struct {
        wmw_pkg::kind_t                 kind;
        logic [wmw_pkg::RULE_W-1:0]     rule;
        logic [wmw_pkg::SLOT_W-1:0]     slot;
        logic [wmw_pkg::WVAL_W-1:0]     weight;
        logic [wmw_pkg::RULE_W-1:0]     target;
        logic [wmw_pkg::RAND_W-1:0]     rand_sym;
        logic [wmw_pkg::RAND_W-1:0]     rand_link;
    } walk_item_t;

    typedef struct packed {
        logic                           emitted;
        logic [wmw_pkg::RULE_W-1:0]     sym_rule;
        logic [wmw_pkg::SLOT_W-1:0]     sym_slot;
        logic [wmw_pkg::RULE_W-1:0]     next_rule;
        logic [wmw_pkg::COUNT_W-1:0]    count;
        logic                           done;
    } walk_result_t;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [wmw_pkg::PADDR_W-1:0]      paddr;
    logic [wmw_pkg::PDATA_W-1:0]      pwdata;
    logic [wmw_pkg::PDATA_W-1:0]      prdata;
    logic                             pready;
    logic                             s_tvalid;
    logic                             s_tready;
    // rule, slot, weight, target, rand_sym, rand_link
    logic [wmw_pkg::S_TDATA_W-1:0]    s_tdata;
    logic [wmw_pkg::KIND_W-1:0]       s_tuser;   // kind
    logic                             m_tvalid;
    logic                             m_tready;
    // sym_rule, sym_slot, next_rule, count
    logic [wmw_pkg::M_TDATA_W-1:0]    m_tdata;
    logic [0:0]                       m_tuser;   // emitted
    logic                             m_tlast;   // walk done

    weighted_markov_walk dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // walk model state
    logic [wmw_pkg::WEIGHT_BITS-1:0] sym_weight  [wmw_pkg::TABLE_DEPTH];
    logic [wmw_pkg::WEIGHT_BITS-1:0] link_weight [wmw_pkg::TABLE_DEPTH];
    logic [wmw_pkg::RULE_W-1:0]      link_target [wmw_pkg::TABLE_DEPTH];
    logic [wmw_pkg::TOTAL_BITS-1:0]  sym_total   [wmw_pkg::RULE_COUNT];
    logic [wmw_pkg::TOTAL_BITS-1:0]  link_total  [wmw_pkg::RULE_COUNT];
    logic [wmw_pkg::RULE_W-1:0]      walk_rule;
    logic [wmw_pkg::COUNT_W-1:0]     walk_count;
    logic                            walk_over;
    logic [wmw_pkg::COUNT_W-1:0]     walk_length;

    walk_result_t walk_results_due[$];
    walk_result_t seen_result;
    walk_result_t due_result;

    int unsigned items_sent;
    int unsigned mismatch_count;
    int unsigned burst_left;
    bit          sender_steady;
    bit          rx_steady;
    bit          hold_request;
    int unsigned stall_left;

    // ------------------------------------------------------------------------
    // walk model
    // ------------------------------------------------------------------------
    // first slot whose running weight sum exceeds r
    function automatic logic [wmw_pkg::SLOT_W-1:0] pick_weighted(
        input logic                         from_links,
        input logic [wmw_pkg::RULE_W-1:0]   rule,
        input logic [wmw_pkg::RAND_W-1:0]   r);
        longint unsigned acc;
        acc = 0;
        for (int k = 0; k < wmw_pkg::SLOT_COUNT; k++)
        begin
            acc += from_links ? link_weight[rule*wmw_pkg::SLOT_COUNT + k]
                              : sym_weight[rule*wmw_pkg::SLOT_COUNT + k];
            if (acc > r)
                return wmw_pkg::SLOT_W'(k);
        end
        return wmw_pkg::SLOT_W'(wmw_pkg::SLOT_COUNT - 1);
    endfunction

    task automatic predict_walk(input walk_item_t it);
        walk_result_t                 res;
        int unsigned                  idx;
        logic [wmw_pkg::RAND_W-1:0]   r;
        logic [wmw_pkg::SLOT_W-1:0]   k;
        res = '0;
        idx = it.rule * wmw_pkg::SLOT_COUNT + it.slot;
        case (it.kind)
            wmw_pkg::KIND_SYMBOL:
            begin
                sym_total[it.rule] = sym_total[it.rule] - sym_weight[idx] + it.weight;
                sym_weight[idx]    = it.weight;
            end
            wmw_pkg::KIND_LINK:
            begin
                link_total[it.rule] = link_total[it.rule] - link_weight[idx] + it.weight;
                link_weight[idx]    = it.weight;
                link_target[idx]    = it.target;
            end
            default:
            begin
                if (it.kind == wmw_pkg::KIND_START)
                begin
                    walk_rule  = '0;
                    walk_count = '0;
                    walk_over  = (walk_length == 0);
                end
                else if (!walk_over)
                begin
                    if (walk_count >= walk_length)
                        walk_over = 1'b1;
                    else
                    begin
                        if (sym_total[walk_rule] != 0)
                        begin
                            r = it.rand_sym % sym_total[walk_rule];
                            res.emitted  = 1'b1;
                            res.sym_rule = walk_rule;
                            res.sym_slot = pick_weighted(1'b0, walk_rule, r);
                            walk_count   = walk_count + 1'b1;
                        end
                        if (link_total[walk_rule] == 0)
                            walk_over = 1'b1;
                        else
                        begin
                            r = it.rand_link % link_total[walk_rule];
                            k = pick_weighted(1'b1, walk_rule, r);
                            walk_rule = link_target[walk_rule*wmw_pkg::SLOT_COUNT + k];
                            if (walk_count >= walk_length)
                                walk_over = 1'b1;
                        end
                    end
                end
                res.next_rule = walk_rule;
                res.count     = walk_count;
                res.done      = walk_over;
                walk_results_due.push_back(res);
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input walk_result_t want,
                                   input walk_result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t %s: expected emit=%0d rule=%0d slot=%0d next=%0d cnt=%0d done=%0d,",
                     $time, what, want.emitted, want.sym_rule, want.sym_slot,
                     want.next_rule, want.count, want.done,
                     " got emit=%0d rule=%0d slot=%0d next=%0d cnt=%0d done=%0d",
                     got.emitted, got.sym_rule, got.sym_slot, got.next_rule,
                     got.count, got.done);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen_result.emitted   = m_tuser[0];
            seen_result.sym_rule  = m_tdata[3:0];
            seen_result.sym_slot  = m_tdata[6:4];
            seen_result.next_rule = m_tdata[10:7];
            seen_result.count     = m_tdata[18:11];
            seen_result.done      = m_tlast;
            if (walk_results_due.size() == 0)
                report_mismatch("result with none due", '0, seen_result);
            else
            begin
                due_result = walk_results_due.pop_front();
                if (seen_result.emitted   !== due_result.emitted   ||
                    seen_result.sym_rule  !== due_result.sym_rule  ||
                    seen_result.sym_slot  !== due_result.sym_slot  ||
                    seen_result.next_rule !== due_result.next_rule ||
                    seen_result.count     !== due_result.count     ||
                    seen_result.done      !== due_result.done)
                    report_mismatch("walk result mismatch", due_result, seen_result);
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: short random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin
        m_tready   = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end
            else if (!rx_steady && $urandom_range(0, 3) == 0)
            begin
                stall_left = $urandom_range(0, 7);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------
    function automatic logic [wmw_pkg::WVAL_W-1:0] rand_weight();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return wmw_pkg::WVAL_W'($urandom_range(1, 20));
            default: return wmw_pkg::WVAL_W'($urandom);
        endcase
    endfunction

    function automatic logic [wmw_pkg::RAND_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return wmw_pkg::RAND_W'($urandom_range(0, 100));
            default: return wmw_pkg::RAND_W'($urandom);
        endcase
    endfunction

    function automatic walk_item_t random_item();
        walk_item_t it;
        it.kind      = wmw_pkg::kind_t'($urandom_range(0, 3));
        it.rule      = wmw_pkg::RULE_W'($urandom_range(0, wmw_pkg::RULE_COUNT - 1));
        it.slot      = wmw_pkg::SLOT_W'($urandom_range(0, wmw_pkg::SLOT_COUNT - 1));
        it.weight    = rand_weight();
        it.target    = wmw_pkg::RULE_W'($urandom_range(0, wmw_pkg::RULE_COUNT - 1));
        it.rand_sym  = rand_value();
        it.rand_link = rand_value();
        return it;
    endfunction

    // called at a falling edge, returns at a falling edge with valid still up
    task automatic send_item(input walk_item_t it);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = sender_steady ? 0 : $urandom_range(0, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {7'b0, it.rand_link, it.rand_sym, it.target, it.weight,
                     it.slot, it.rule};
        do
            @(posedge clk);
        while (!s_tready);
        predict_walk(it);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_symbol_weight(input int rule, input int slot, input int w);
        walk_item_t it;
        it        = random_item();
        it.kind   = wmw_pkg::KIND_SYMBOL;
        it.rule   = wmw_pkg::RULE_W'(rule);
        it.slot   = wmw_pkg::SLOT_W'(slot);
        it.weight = wmw_pkg::WVAL_W'(w);
        send_item(it);
    endtask

    task automatic send_link(input int rule, input int slot, input int w, input int tgt);
        walk_item_t it;
        it        = random_item();
        it.kind   = wmw_pkg::KIND_LINK;
        it.rule   = wmw_pkg::RULE_W'(rule);
        it.slot   = wmw_pkg::SLOT_W'(slot);
        it.weight = wmw_pkg::WVAL_W'(w);
        it.target = wmw_pkg::RULE_W'(tgt);
        send_item(it);
    endtask

    task automatic send_start();
        walk_item_t it;
        it      = random_item();
        it.kind = wmw_pkg::KIND_START;
        send_item(it);
    endtask

    task automatic send_step(input logic [wmw_pkg::RAND_W-1:0] rs,
                             input logic [wmw_pkg::RAND_W-1:0] rc);
        walk_item_t it;
        it           = random_item();
        it.kind      = wmw_pkg::KIND_STEP;
        it.rand_sym  = rs;
        it.rand_link = rc;
        send_item(it);
    endtask

    // drop valid, let every result come back, then let a trailing write finish
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (walk_results_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_name_length(input int len);
        wait_idle();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {wmw_pkg::REG_NAME_LENGTH, 2'b00};
        pwdata  <= wmw_pkg::PDATA_W'(len);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        walk_length = wmw_pkg::COUNT_W'(len);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_empty_tables();
        send_step('1, '1);          // no walk active yet
        send_start();
        send_step('0, '0);          // no symbols, no connections: walk ends
    endtask

    task automatic test_weight_extremes();
        send_symbol_weight(0, 0, 1);
        send_symbol_weight(0, 7, 16'hFFFF);
        send_link(0, 0, 16'hFFFF, 15);
        send_symbol_weight(15, 3, 5);
        send_symbol_weight(0, 7, 0);        // overwrite drops the total
        send_symbol_weight(0, 7, 16'hFFFF);
        send_start();
        send_step('0, '1);
        send_step('1, '0);          // rule 15 has no connections
        send_step(rand_value(), rand_value());
    endtask

    task automatic test_symbolless_rule();
        send_link(0, 0, 0, 0);
        send_link(0, 6, 3, 5);
        send_link(5, 2, 7, 0);
        send_start();
        send_step(wmw_pkg::RAND_W'(12345), '1);
        send_step('1, wmw_pkg::RAND_W'(6));  // rule 5: move only
    endtask

    task automatic test_length_limits();
        set_name_length(2);
        send_start();
        repeat (4) send_step(rand_value(), rand_value());
        set_name_length(0);
        send_start();
        send_step(rand_value(), rand_value());
        set_name_length(255);
        send_start();
        repeat (2) send_step(rand_value(), rand_value());
        // lowering below the count ends the walk on the next step
        set_name_length(1);
        send_step(rand_value(), rand_value());
    endtask

    task automatic test_output_backpressure();
        set_name_length(255);
        send_start();
        hold_request = 1'b1;
        sender_steady = 1'b1;
        repeat (8) send_step(rand_value(), rand_value());
        sender_steady = 1'b0;
    endtask

    task automatic test_random_walks(input int unsigned item_budget);
        int unsigned stop_at;
        int unsigned walk_no;
        walk_item_t  it;
        stop_at = items_sent + item_budget;
        for (int r = 0; r < wmw_pkg::RULE_COUNT; r++)
        begin
            repeat (2) send_symbol_weight(r, $urandom_range(0, 7), rand_weight());
            repeat (2) send_link(r, $urandom_range(0, 7), $urandom_range(1, 300),
                                 $urandom_range(0, 15));
        end
        walk_no = 0;
        while (items_sent < stop_at)
        begin
            if (walk_no % 4 == 0)
            begin
                case ($urandom_range(0, 7))
                    0:       set_name_length(0);
                    1:       set_name_length(1);
                    2:       set_name_length(255);
                    3:       set_name_length(8);
                    default: set_name_length($urandom_range(2, 20));
                endcase
                sender_steady = ($urandom_range(0, 3) == 0);
                rx_steady     = ($urandom_range(0, 3) == 0);
            end
            repeat ($urandom_range(0, 4))
            begin
                it = random_item();
                it.kind = $urandom_range(0, 1) ? wmw_pkg::KIND_SYMBOL : wmw_pkg::KIND_LINK;
                send_item(it);
            end
            send_start();
            repeat ($urandom_range(1, 20))
            begin
                if ($urandom_range(0, 9) == 0)
                    send_item(random_item());
                else
                    send_step(rand_value(), rand_value());
            end
            walk_no++;
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = wmw_pkg::KIND_SYMBOL;
        items_sent     = 0;
        mismatch_count = 0;
        burst_left     = 0;
        sender_steady  = 1'b0;
        rx_steady      = 1'b0;
        hold_request   = 1'b0;
        for (int i = 0; i < wmw_pkg::TABLE_DEPTH; i++)
        begin
            sym_weight[i]  = '0;
            link_weight[i] = '0;
            link_target[i] = '0;
        end
        for (int i = 0; i < wmw_pkg::RULE_COUNT; i++)
        begin
            sym_total[i]  = '0;
            link_total[i] = '0;
        end
        walk_rule   = '0;
        walk_count  = '0;
        walk_over   = 1'b1;
        walk_length = wmw_pkg::NAME_LENGTH_RESET;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(negedge clk);

        test_empty_tables();
        test_weight_extremes();
        test_symbolless_rule();
        test_length_limits();
        test_output_backpressure();
        test_random_walks(RANDOM_ITEMS);

        s_tvalid <= 1'b0;
        while (walk_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && walk_results_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
